// ===== design/vietnamese_text_normalizer_defines.svh =====
// ============================================================================
// Vietnamese text normaliser - assertion macros
// Shared property shorthands for the concurrent checks of the block.
// ============================================================================
`ifndef VIETNAMESE_TEXT_NORMALIZER_DEFINES_SVH
`define VIETNAMESE_TEXT_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define VTN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vtn check failed");

// Next-cycle implication, disabled while reset is held.
`define VTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vtn check failed");

`endif

// ===== design/vtn_pkg.sv =====
// ============================================================================
// vtn_pkg
// Shared constants, packet type and letter lookups of the text normaliser.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package vtn_pkg;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_D = 8'h44;
    localparam logic [7:0] CHAR_UPPER_E = 8'h45;
    localparam logic [7:0] CHAR_UPPER_I = 8'h49;
    localparam logic [7:0] CHAR_UPPER_O = 8'h4F;
    localparam logic [7:0] CHAR_UPPER_U = 8'h55;
    localparam logic [7:0] CHAR_UPPER_Y = 8'h59;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT     = 8'h20;
    localparam logic [7:0] NO_MATCH     = 8'h00;

    // Lead and middle bytes of letter candidates.
    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C4 = 8'hC4;
    localparam logic [7:0] LEAD_C5 = 8'hC5;
    localparam logic [7:0] LEAD_C6 = 8'hC6;
    localparam logic [7:0] LEAD_3B = 8'hE1;
    localparam logic [7:0] MID_LO  = 8'hBA;
    localparam logic [7:0] MID_HI  = 8'hBB;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PKT_SLOTS   = 3;

    // Up to three bytes caused by one input word; no bytes means a bare end marker.
    typedef struct packed {
        logic [PKT_SLOTS-1:0][7:0] bytes;
        logic [1:0]                n_bytes;
        logic                      last;
    } t_packet;

    // Upper-case base letter for U+00C0..U+00DF, indexed by the low five bits.
    function automatic logic [7:0] f_latin1_base(input logic [4:0] idx);
        logic [7:0] base;
        unique case (idx)
            5'h00, 5'h01, 5'h02, 5'h03: base = CHAR_UPPER_A;
            5'h08, 5'h09, 5'h0A:        base = CHAR_UPPER_E;
            5'h0C, 5'h0D:               base = CHAR_UPPER_I;
            5'h12, 5'h13, 5'h14, 5'h15: base = CHAR_UPPER_O;
            5'h19, 5'h1A:               base = CHAR_UPPER_U;
            5'h1D:                      base = CHAR_UPPER_Y;
            default:                    base = NO_MATCH;
        endcase
        return base;
    endfunction

    // Two-byte letters; NO_MATCH when the pair is not one of them.
    function automatic logic [7:0] f_lookup2(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] base;
        logic [7:0] res;
        base = f_latin1_base(b[4:0]);
        res  = NO_MATCH;
        if (b[7:6] == 2'b10) begin
            unique case (lead)
                LEAD_C3: begin
                    if (base != NO_MATCH) begin
                        res = b[5] ? (base | CASE_BIT) : base;
                    end
                end
                LEAD_C4: begin
                    unique case (b)
                        8'h82:   res = CHAR_UPPER_A;
                        8'h83:   res = CHAR_UPPER_A | CASE_BIT;
                        8'h90:   res = CHAR_UPPER_D;
                        8'h91:   res = CHAR_UPPER_D | CASE_BIT;
                        8'hA8:   res = CHAR_UPPER_I;
                        8'hA9:   res = CHAR_UPPER_I | CASE_BIT;
                        default: res = NO_MATCH;
                    endcase
                end
                LEAD_C5: begin
                    unique case (b)
                        8'hA8:   res = CHAR_UPPER_U;
                        8'hA9:   res = CHAR_UPPER_U | CASE_BIT;
                        default: res = NO_MATCH;
                    endcase
                end
                LEAD_C6: begin
                    unique case (b)
                        8'hA0:   res = CHAR_UPPER_O;
                        8'hA1:   res = CHAR_UPPER_O | CASE_BIT;
                        8'hAF:   res = CHAR_UPPER_U;
                        8'hB0:   res = CHAR_UPPER_U | CASE_BIT;
                        default: res = NO_MATCH;
                    endcase
                end
                default: res = NO_MATCH;
            endcase
        end
        return res;
    endfunction

    // Three-byte letters U+1EA0..U+1EF9 after the lead and a middle byte.
    function automatic logic [7:0] f_lookup3(input logic [7:0] mid, input logic [7:0] b);
        logic [6:0] off;
        logic       hit;
        logic [7:0] base;
        if (mid == MID_HI) begin
            off = 7'(b[5:0]) + 7'd32;
            hit = (off < 7'd90);
        end else begin
            off = {2'b00, b[4:0]};
            hit = b[5];
        end
        hit = hit && (b[7:6] == 2'b10);
        if (off < 7'd24) begin
            base = CHAR_UPPER_A;
        end else if (off < 7'd40) begin
            base = CHAR_UPPER_E;
        end else if (off < 7'd44) begin
            base = CHAR_UPPER_I;
        end else if (off < 7'd68) begin
            base = CHAR_UPPER_O;
        end else if (off < 7'd82) begin
            base = CHAR_UPPER_U;
        end else begin
            base = CHAR_UPPER_Y;
        end
        if (!hit) begin
            return NO_MATCH;
        end
        return off[0] ? (base | CASE_BIT) : base;
    endfunction

endpackage

`default_nettype wire

// ===== design/vtn_stream_if.sv =====
// ============================================================================
// vtn_in_if / vtn_out_if
// Valid/ready channels for input text bytes and normalised result words.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface vtn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface vtn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output out_byte, output has_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== design/vietnamese_text_normalizer.sv =====
// ============================================================================
// vietnamese_text_normalizer
// Streaming UTF-8 diacritic stripper with space collapsing.
// ============================================================================
// The block takes UTF-8 text one byte per word on i_in and returns normalised
// text one byte per word on o_out. ASCII capitals are lowercased, the
// Vietnamese accented letters become their plain base letter (accented
// capitals stay upper case), other bytes pass through untouched, runs of
// spaces collapse to one, a trailing space is dropped and end_of_text closes
// a string: its final result word has last set, and a string end that gives
// no byte produces a bare word with has_byte low. An input byte is taken in
// every cycle while the packet queue has room, and a result word leaves in
// every cycle that the sink is ready and a packet is held; one input byte
// causes from zero to three output words, which the serialiser hands out in
// turn, so the sustained input rate is one byte per cycle for text whose
// bytes map one to one and is lower where each byte causes several words.
// The queue (QUEUE_DEPTH packets) absorbs short bursts such as a flushed
// broken sequence. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "vietnamese_text_normalizer_defines.svh"

module vietnamese_text_normalizer #(
    parameter int unsigned QUEUE_DEPTH = vtn_pkg::QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vtn_in_if.sink    i_in,
    vtn_out_if.source o_out
);

    // Front end: decodes each byte into a packet of result bytes.
    vtn_pkg::t_packet w_front_pkt;
    logic             w_push;
    logic             w_q_ready;

    // Queue to back end.
    vtn_pkg::t_packet w_q_pkt;
    logic             w_q_valid;
    logic             w_pop;

    vtn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_pkt     (w_front_pkt),
        .o_push    (w_push)
    );

    // The queue lets the decoder keep taking bytes while the serialiser is
    // still working through a multi-word packet or the sink stalls.
    vtn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_front_pkt),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_pkt   (w_q_pkt),
        .i_pop   (w_pop)
    );

    // Back end: one result word per ready cycle from the held packet.
    vtn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_pkt   (w_q_pkt),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // A word without a byte only ever closes a string.
    `VTN_ASSERT_IMPL(a_bare_is_last, i_clk, i_rst_n, o_out.valid && !o_out.has_byte, o_out.last)
    // Every accepted end of text must leave a packet in the queue.
    `VTN_ASSERT_IMPL(a_end_pushes, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.end_of_text, w_push)
    // The decoder never pushes into a full queue.
    `VTN_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, w_push, w_q_ready)

endmodule

`default_nettype wire

// ===== design/vtn_front.sv =====
// ============================================================================
// vtn_front
// Decodes a byte a cycle, while the queue has room, into up to three bytes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vtn_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    vtn_in_if.sink          i_in,
    input  wire logic       i_q_ready,
    output vtn_pkg::t_packet o_pkt,
    output logic            o_push
);

    logic [7:0] r_buf0, r_buf1;
    logic [1:0] r_cnt;
    logic       r_three, r_space_pending, r_last_was_space;

    logic [7:0] n_buf0, n_buf1;
    logic [1:0] n_cnt;
    logic       n_three, n_space_pending, n_last_was_space;

    logic [1:0]       n_out;
    vtn_pkg::t_packet n_pkt;
    logic             fresh;
    logic [7:0]       c2, c3, b;
    logic             accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign b          = i_in.in_byte;
    assign c2         = vtn_pkg::f_lookup2(r_buf0, b);
    assign c3         = vtn_pkg::f_lookup3(r_buf1, b);

    always_comb begin
        n_buf0           = r_buf0;
        n_buf1           = r_buf1;
        n_cnt            = r_cnt;
        n_three          = r_three;
        n_space_pending  = r_space_pending;
        n_last_was_space = r_last_was_space;
        n_pkt            = '0;
        n_out            = 2'd0;
        fresh            = 1'b0;

        // Resolve an open candidate first.
        if (r_cnt == 2'd0) begin
            fresh = 1'b1;
        end else if (r_cnt == 2'd1 && !r_three) begin
            if (c2 != vtn_pkg::NO_MATCH) begin
                n_pkt.bytes[n_out] = c2;
                n_out = n_out + 2'd1;
            end else begin
                n_pkt.bytes[n_out] = r_buf0;
                n_out = n_out + 2'd1;
                fresh = 1'b1;
            end
            n_cnt = 2'd0;
        end else if (r_cnt == 2'd1) begin
            if (b == vtn_pkg::MID_LO || b == vtn_pkg::MID_HI) begin
                n_buf1 = b;
                n_cnt  = 2'd2;
            end else begin
                n_pkt.bytes[n_out] = r_buf0;
                n_out = n_out + 2'd1;
                n_cnt = 2'd0;
                fresh = 1'b1;
            end
        end else begin
            if (c3 != vtn_pkg::NO_MATCH) begin
                n_pkt.bytes[n_out] = c3;
                n_out = n_out + 2'd1;
            end else begin
                n_pkt.bytes[n_out] = r_buf0;
                n_out = n_out + 2'd1;
                n_pkt.bytes[n_out] = r_buf1;
                n_out = n_out + 2'd1;
                fresh = 1'b1;
            end
            n_cnt = 2'd0;
        end

        // Handle the byte on its own.
        if (fresh) begin
            if (b == vtn_pkg::CHAR_SPACE) begin
                if (!r_last_was_space) begin
                    n_space_pending  = 1'b1;
                    n_last_was_space = 1'b1;
                end
            end else begin
                if (r_space_pending) begin
                    n_pkt.bytes[n_out] = vtn_pkg::CHAR_SPACE;
                    n_out = n_out + 2'd1;
                    n_space_pending = 1'b0;
                end
                n_last_was_space = 1'b0;
                if (b >= vtn_pkg::LEAD_C3 && b <= vtn_pkg::LEAD_C6) begin
                    n_buf0  = b;
                    n_cnt   = 2'd1;
                    n_three = 1'b0;
                end else if (b == vtn_pkg::LEAD_3B) begin
                    n_buf0  = b;
                    n_cnt   = 2'd1;
                    n_three = 1'b1;
                end else if (b >= vtn_pkg::CHAR_UPPER_A && b <= vtn_pkg::CHAR_UPPER_Z) begin
                    n_pkt.bytes[n_out] = b | vtn_pkg::CASE_BIT;
                    n_out = n_out + 2'd1;
                end else begin
                    n_pkt.bytes[n_out] = b;
                    n_out = n_out + 2'd1;
                end
            end
        end

        // End of text: held bytes go out raw and everything returns to reset.
        if (i_in.end_of_text) begin
            if (n_cnt >= 2'd1) begin
                n_pkt.bytes[n_out] = n_buf0;
                n_out = n_out + 2'd1;
            end
            if (n_cnt >= 2'd2) begin
                n_pkt.bytes[n_out] = n_buf1;
                n_out = n_out + 2'd1;
            end
            n_cnt            = 2'd0;
            n_three          = 1'b0;
            n_space_pending  = 1'b0;
            n_last_was_space = 1'b0;
        end

        n_pkt.n_bytes = n_out;
        n_pkt.last    = i_in.end_of_text;
    end

    assign o_pkt  = n_pkt;
    assign o_push = accept && ((n_out != 2'd0) || i_in.end_of_text);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt            <= 2'd0;
            r_three          <= 1'b0;
            r_space_pending  <= 1'b0;
            r_last_was_space <= 1'b0;
        end else if (accept) begin
            r_cnt            <= n_cnt;
            r_three          <= n_three;
            r_space_pending  <= n_space_pending;
            r_last_was_space <= n_last_was_space;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf0 <= n_buf0;
            r_buf1 <= n_buf1;
        end
    end

endmodule

`default_nettype wire

// ===== design/vtn_queue.sv =====
// ============================================================================
// vtn_queue
// Small first-in first-out store of packets between decoder and serialiser.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vtn_queue #(
    parameter int unsigned DEPTH = vtn_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire vtn_pkg::t_packet i_pkt,
    output logic                  o_ready,
    output logic                  o_valid,
    output vtn_pkg::t_packet      o_pkt,
    input  wire logic             i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    vtn_pkg::t_packet r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_pkt   = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

endmodule

`default_nettype wire

// ===== design/vtn_back.sv =====
// ============================================================================
// vtn_back
// Holds one packet and hands its result words out one per ready cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vtn_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire vtn_pkg::t_packet i_pkt,
    output logic                  o_pop,
    vtn_out_if.source             o_out
);

    vtn_pkg::t_packet r_pkt;
    logic             r_busy;
    logic [1:0]       r_idx;
    logic             at_end, fire, take, has;

    assign has    = (r_pkt.n_bytes != 2'd0);
    assign at_end = !has || (r_idx == r_pkt.n_bytes - 2'd1);
    assign fire   = r_busy && o_out.ready;
    assign take   = i_valid && (!r_busy || (fire && at_end));
    assign o_pop  = take;

    assign o_out.valid    = r_busy;
    assign o_out.out_byte = has ? r_pkt.bytes[r_idx] : 8'h00;
    assign o_out.has_byte = has;
    assign o_out.last     = r_pkt.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (fire) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pkt <= i_pkt;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the Vietnamese text normaliser
// Feeds UTF-8 text one byte per word, predicts every normalised result word
// from a behavioural copy of the stripping rules and checks the words that
// leave the block, in order, under random stalls on both channels, then none.
// ----------------------------------------------------------------------------

module tb_top;
    import vtn_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 20;

    // One normalised result word as the block should return it.
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } text_word_t;

    logic clk;
    logic rst_n;

    vtn_in_if  in_ch ();
    vtn_out_if out_ch ();

    vietnamese_text_normalizer u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: the open letter candidate and the space tracking.
    logic [7:0]  held [2];
    int unsigned held_n;
    int unsigned held_len;
    logic        gap_pending;
    logic        after_space;

    text_word_t  step_words [$];
    text_word_t  norm_q [$];
    logic [7:0]  text_q [$];

    int unsigned mismatches;
    int unsigned sent_count;
    int unsigned cycle_count;
    logic        idle_on;

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Letter tables
    // ------------------------------------------------------------------------
    // Base letter of a two-byte letter; zero when the pair is not a letter.
    function automatic logic [7:0] strip_pair(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] base;
        base = 8'h00;
        if (b[7:6] == 2'b10) begin
            case (lead)
                LEAD_C3: begin
                    case (b[4:0])
                        5'h00, 5'h01, 5'h02, 5'h03: base = CHAR_UPPER_A;
                        5'h08, 5'h09, 5'h0A:        base = CHAR_UPPER_E;
                        5'h0C, 5'h0D:               base = CHAR_UPPER_I;
                        5'h12, 5'h13, 5'h14, 5'h15: base = CHAR_UPPER_O;
                        5'h19, 5'h1A:               base = CHAR_UPPER_U;
                        5'h1D:                      base = CHAR_UPPER_Y;
                        default:                    base = 8'h00;
                    endcase
                    if (base != 8'h00 && b[5]) begin
                        base = base | CASE_BIT;
                    end
                end
                LEAD_C4: begin
                    if (b == 8'h82) base = "A";
                    else if (b == 8'h83) base = "a";
                    else if (b == 8'h90) base = "D";
                    else if (b == 8'h91) base = "d";
                    else if (b == 8'hA8) base = "I";
                    else if (b == 8'hA9) base = "i";
                end
                LEAD_C5: begin
                    if (b == 8'hA8) base = "U";
                    else if (b == 8'hA9) base = "u";
                end
                LEAD_C6: begin
                    if (b == 8'hA0) base = "O";
                    else if (b == 8'hA1) base = "o";
                    else if (b == 8'hAF) base = "U";
                    else if (b == 8'hB0) base = "u";
                end
                default: base = 8'h00;
            endcase
        end
        return base;
    endfunction

    // Base letter of a three-byte letter in U+1EA0..U+1EF9; zero otherwise.
    function automatic logic [7:0] strip_triple(input logic [7:0] mid, input logic [7:0] b);
        int         off;
        logic [7:0] base;
        base = 8'h00;
        off  = (mid == MID_HI ? 64 : 0) + int'(b) - 'h80 - 'h20;
        if (b[7:6] == 2'b10 && off >= 0 && off < 90) begin
            if (off < 24)      base = "A";
            else if (off < 40) base = "E";
            else if (off < 44) base = "I";
            else if (off < 68) base = "O";
            else if (off < 82) base = "U";
            else               base = "Y";
            if (off % 2 == 1) begin
                base = base | CASE_BIT;
            end
        end
        return base;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic emit_text(input logic [7:0] b);
        if (step_words.size() < 4) begin
            step_words.push_back('{data: b, has_data: 1'b1, last: 1'b0});
        end
    endtask

    task automatic drop_held();
        held[0]  = 8'h00;
        held[1]  = 8'h00;
        held_n   = 0;
        held_len = 0;
    endtask

    // A candidate that cannot complete leaves as raw bytes.
    task automatic release_held();
        if (held_n >= 1) emit_text(held[0]);
        if (held_n >= 2) emit_text(held[1]);
        drop_held();
    endtask

    task automatic take_fresh(input logic [7:0] b);
        if (b == CHAR_SPACE) begin
            if (!after_space) begin
                gap_pending = 1'b1;
                after_space = 1'b1;
            end
        end else begin
            if (gap_pending) begin
                emit_text(CHAR_SPACE);
                gap_pending = 1'b0;
            end
            after_space = 1'b0;
            if (b >= LEAD_C3 && b <= LEAD_C6) begin
                held[0]  = b;
                held_n   = 1;
                held_len = 2;
            end else if (b == LEAD_3B) begin
                held[0]  = b;
                held_n   = 1;
                held_len = 3;
            end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
                emit_text(b | CASE_BIT);
            end else begin
                emit_text(b);
            end
        end
    endtask

    // Works out the result words of one accepted byte and queues them.
    task automatic predict_text(input logic [7:0] b, input logic eot);
        logic [7:0] c;
        step_words.delete();
        if (held_n == 0) begin
            take_fresh(b);
        end else if (held_n == 1 && held_len == 2) begin
            c = strip_pair(held[0], b);
            if (c != 8'h00) begin
                emit_text(c);
                drop_held();
            end else begin
                release_held();
                take_fresh(b);
            end
        end else if (held_n == 1) begin
            if (b == MID_LO || b == MID_HI) begin
                held[1] = b;
                held_n  = 2;
            end else begin
                release_held();
                take_fresh(b);
            end
        end else begin
            c = strip_triple(held[1], b);
            if (c != 8'h00) begin
                emit_text(c);
                drop_held();
            end else begin
                release_held();
                take_fresh(b);
            end
        end
        if (eot) begin
            release_held();
            gap_pending = 1'b0;
            after_space = 1'b0;
            if (step_words.size() == 0) begin
                step_words.push_back('{data: 8'h00, has_data: 1'b0, last: 1'b1});
            end else begin
                step_words[step_words.size() - 1].last = 1'b1;
            end
        end
        foreach (step_words[i]) begin
            norm_q.push_back(step_words[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready stalls and word checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("tb: mismatch at cycle %0d: %s got %02h want %02h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    initial begin : sink_ready_driver
        int unsigned stall_left;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!idle_on) begin
                stall_left = 0;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : compare_results
        text_word_t got;
        text_word_t want;
        forever begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{data: out_ch.out_byte, has_data: out_ch.has_byte,
                        last: out_ch.last};
                // Let the sender queue what it accepted at this same edge.
                #1;
                if (norm_q.size() == 0) begin
                    report_mismatch("unexpected word", got.data, 8'h00);
                end else begin
                    want = norm_q.pop_front();
                    if (got.has_data !== want.has_data) begin
                        report_mismatch("has_byte", 8'(got.has_data), 8'(want.has_data));
                    end
                    if (want.has_data && got.data !== want.data) begin
                        report_mismatch("out_byte", got.data, want.data);
                    end
                    if (got.last !== want.last) begin
                        report_mismatch("last", 8'(got.last), 8'(want.last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Sends one byte; called right after a rising edge, returns at the edge
    // that accepted it.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        predict_text(b, eot);
        sent_count++;
    endtask

    // Sends the queued text as one string, end_of_text on its final byte.
    task automatic send_text();
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Leading space kept, a run collapsed, capitals lowered, trailing dropped.
    task automatic test_spaces_and_case();
        text_q = '{8'h20, 8'h20, "A", 8'h20, "Z", 8'h01, 8'h20};
        send_text();
    endtask

    task automatic test_letters();
        text_q = '{LEAD_C3, 8'h80, LEAD_C6, 8'hB0, LEAD_3B, MID_HI, 8'hB9};
        send_text();
    endtask

    // Space before a lead, a lead breaking a candidate, a broken third byte,
    // a complete pair that is no letter, and held bytes at the string end.
    task automatic test_broken_sequences();
        text_q = '{8'h20, LEAD_C3, LEAD_C4, 8'h91, LEAD_3B, MID_LO, 8'h20,
                   LEAD_C3, 8'h84, 8'hFF, LEAD_3B, MID_LO};
        send_text();
    endtask

    // A string of nothing but a space gives a bare end marker.
    task automatic test_end_marker();
        text_q = '{8'h20};
        send_text();
    endtask

    // Holds the input off until every predicted word has come out.
    task automatic test_pause_for_drain();
        in_ch.valid <= 1'b0;
        wait (norm_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic add_random_token();
        logic [7:0] lead;
        logic [7:0] mid;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2: text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            3: repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_SPACE);
            4: begin
                // Draw pairs until one is a letter.
                do begin
                    lead = 8'($urandom_range(LEAD_C3, LEAD_C6));
                    b    = 8'($urandom_range(8'h80, 8'hBF));
                end while (strip_pair(lead, b) == 8'h00);
                text_q.push_back(lead);
                text_q.push_back(b);
            end
            5: begin
                mid = $urandom_range(0, 1) ? MID_HI : MID_LO;
                b   = (mid == MID_HI) ? 8'($urandom_range(8'h80, 8'hB9))
                                      : 8'($urandom_range(8'hA0, 8'hBF));
                text_q.push_back(LEAD_3B);
                text_q.push_back(mid);
                text_q.push_back(b);
            end
            6: begin
                if ($urandom_range(0, 1)) begin
                    text_q.push_back(8'($urandom_range(LEAD_C3, LEAD_C6)));
                end else begin
                    text_q.push_back(LEAD_3B);
                    text_q.push_back($urandom_range(0, 1) ? MID_HI : MID_LO);
                end
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            7: text_q.push_back(8'($urandom_range(1, 255)));
            8: begin
                text_q.push_back(LEAD_3B);
                text_q.push_back($urandom_range(0, 1) ? MID_HI : MID_LO);
            end
            default: text_q.push_back(8'($urandom_range(LEAD_C3, LEAD_C6)));
        endcase
    endtask

    // Random strings of letters, spaces and broken sequences until the byte
    // count reaches the given mark.
    task automatic test_random_text(input int unsigned until_count);
        while (sent_count < until_count) begin
            repeat ($urandom_range(1, 8)) add_random_token();
            send_text();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatches  = 0;
        sent_count  = 0;
        idle_on     = 1'b1;
        drop_held();
        gap_pending = 1'b0;
        after_space = 1'b0;

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_spaces_and_case();
        test_letters();
        test_broken_sequences();
        test_end_marker();
        test_pause_for_drain();
        test_random_text(sent_count + 60);
        test_pause_for_drain();
        idle_on = 1'b0;
        test_random_text(sent_count + 25);

        in_ch.valid <= 1'b0;
        wait (norm_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== vietnamese_text_normalizer.f =====
+incdir+design
design/vtn_pkg.sv
design/vtn_stream_if.sv
design/vtn_front.sv
design/vtn_queue.sv
design/vtn_back.sv
design/vietnamese_text_normalizer.sv
test/tb_top.sv
